// ===== rtl/assert_macros.svh =====
// assertion macros shared by the posting list merge rtl
// no dependencies; assertions are clocked on aclk and disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PLM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed in posting list merge");

// expression must never be true out of reset
`define PLM_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("forbidden condition in posting list merge");

`endif

// ===== rtl/plm_pkg.sv =====
// types, constants and codes of the posting list merge block
// no dependencies; imported by every module of the block
package plm_pkg;

    // field widths
    localparam int ID_W       = 32;
    localparam int SCORE_W    = 16;
    localparam int WEIGHT_W   = 8;
    localparam int PROD_W     = SCORE_W + WEIGHT_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int FRAC_SHIFT = 4;

    // posting queues per side
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_WEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_WEIGHT = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd16;

    typedef enum logic [1:0] {
        KIND_ENTRY,
        KIND_END,
        KIND_OVERFLOW
    } kind_t;

    typedef enum logic [1:0] {
        OP_DATA_L,
        OP_DATA_R,
        OP_END_L,
        OP_END_R
    } cmd_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_LOAD,
        ST_DRAIN,
        ST_MULT,
        ST_MATCH,
        ST_FLUSH
    } back_state_t;

    typedef struct packed {
        logic               side;
        logic               list_end;
        logic [ID_W-1:0]    doc_id;
        logic [SCORE_W-1:0] doc_score;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    out_doc;
        logic [SCORE_W-1:0] out_score;
        logic               last;
    } out_item_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [ID_W-1:0]    doc_id;
        logic [SCORE_W-1:0] doc_score;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } qentry_t;

    typedef struct packed {
        logic                merge_mode;
        logic [WEIGHT_W-1:0] left_weight;
        logic [WEIGHT_W-1:0] right_weight;
    } cfg_t;

endpackage

// ===== rtl/plm_front.sv =====
// front of the posting list merge: accepts input transactions, classifies them
// into commands and buffers them in a short queue; depends on plm_pkg
module plm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  plm_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output plm_pkg::cmd_t     cmd
);
    import plm_pkg::*;

    cmd_t                  q_mem_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;
    cmd_t                  cls_cmd;
    logic                  push;
    logic                  pop;

    function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
        if (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // classify the incoming item by side and end mark
    always_comb begin
        if (s_data.list_end) begin
            cls_cmd.op = s_data.side ? OP_END_R : OP_END_L;
        end else begin
            cls_cmd.op = s_data.side ? OP_DATA_R : OP_DATA_L;
        end
        cls_cmd.doc_id    = s_data.doc_id;
        cls_cmd.doc_score = s_data.doc_score;
    end

    // queue handshakes
    assign s_ready   = (cnt_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

// ===== rtl/plm_back.sv =====
// back of the posting list merge: per side posting queues, merge sequencer,
// score combiner and result register; depends on plm_pkg and assert_macros.svh
`include "assert_macros.svh"

module plm_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  plm_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  plm_pkg::cmd_t      cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output plm_pkg::out_item_t m_data
);
    import plm_pkg::*;

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg;
    logic [PTR_W-1:0]    l_head_reg, l_head_next, r_head_reg, r_head_next;
    logic [CNT_W-1:0]    l_cnt_reg, l_cnt_next, r_cnt_reg, r_cnt_next;
    logic                l_done_reg, l_done_next, r_done_reg, r_done_next;
    logic                run_fin_reg, run_fin_next;
    logic [PROD_W-1:0]   prod_l_reg, prod_r_reg;
    logic                pend_valid_reg, pend_valid_next;
    out_item_t           pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    qentry_t             l_mem [QUEUE_DEPTH];
    qentry_t             r_mem [QUEUE_DEPTH];
    qentry_t             l_rd_reg, r_rd_reg;
    logic                l_we, r_we;
    logic [PTR_W-1:0]    l_tail, r_tail;
    qentry_t             wr_entry;

    logic                out_free, can_emit;
    logic                emit_req;
    out_item_t           emit_item;
    logic                is_end, is_right, l_done_new, r_done_new;
    logic                mode_or;
    logic [SUM_W-1:0]    score_sum;
    logic [SUM_W-FRAC_SHIFT-1:0] score_shr;
    logic [SCORE_W-1:0]  score_sat;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] tail_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(cnt);
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic out_item_t make_item(input kind_t k, input logic [ID_W-1:0] doc,
                                            input logic [SCORE_W-1:0] sc);
        out_item_t it;
        it.kind      = k;
        it.out_doc   = doc;
        it.out_score = sc;
        it.last      = 1'b0;
        return it;
    endfunction

    // command decode
    assign is_end     = (cmd_reg.op == OP_END_L) || (cmd_reg.op == OP_END_R);
    assign is_right   = (cmd_reg.op == OP_DATA_R) || (cmd_reg.op == OP_END_R);
    assign l_done_new = l_done_reg || (is_end && !is_right);
    assign r_done_new = r_done_reg || (is_end && is_right);
    assign mode_or    = cfg.merge_mode;

    // queue write address and data
    assign l_tail             = tail_of(l_head_reg, l_cnt_reg);
    assign r_tail             = tail_of(r_head_reg, r_cnt_reg);
    assign wr_entry.id        = cmd_reg.doc_id;
    assign wr_entry.score     = cmd_reg.doc_score;

    // combined score: sum of q12.12 products back to q8.8, saturated
    assign score_sum = SUM_W'(prod_l_reg) + SUM_W'(prod_r_reg);
    assign score_shr = score_sum[SUM_W-1:FRAC_SHIFT];
    assign score_sat = (|score_shr[SUM_W-FRAC_SHIFT-1:SCORE_W]) ? {SCORE_W{1'b1}}
                                                                : score_shr[SCORE_W-1:0];

    // result slots: output register plus one pending result that waits for its last flag
    assign out_free  = !out_valid_reg || m_ready;
    assign can_emit  = !pend_valid_reg || out_free;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // sequencer next state and datapath control
    always_comb begin
        state_next      = state_reg;
        l_head_next     = l_head_reg;
        r_head_next     = r_head_reg;
        l_cnt_next      = l_cnt_reg;
        r_cnt_next      = r_cnt_reg;
        l_done_next     = l_done_reg;
        r_done_next     = r_done_reg;
        run_fin_next    = run_fin_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        l_we            = 1'b0;
        r_we            = 1'b0;
        emit_req        = 1'b0;
        emit_item       = make_item(KIND_END, '0, '0);

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    state_next = ST_APPLY;
                end
            end

            ST_APPLY: begin
                if (run_fin_reg) begin
                    // run over: only end marks count, both of them clear the state
                    l_done_next = l_done_new;
                    r_done_next = r_done_new;
                    if (l_done_new && r_done_new) begin
                        l_done_next  = 1'b0;
                        r_done_next  = 1'b0;
                        run_fin_next = 1'b0;
                        l_head_next  = '0;
                        r_head_next  = '0;
                        l_cnt_next   = '0;
                        r_cnt_next   = '0;
                    end
                    state_next = ST_IDLE;
                end else if (is_end) begin
                    l_done_next = l_done_new;
                    r_done_next = r_done_new;
                    state_next  = ST_LOAD;
                end else if (is_right ? r_done_reg : l_done_reg) begin
                    state_next = ST_LOAD;
                end else if ((is_right ? r_cnt_reg : l_cnt_reg) == CNT_W'(QUEUE_DEPTH)) begin
                    emit_req  = 1'b1;
                    emit_item = make_item(KIND_OVERFLOW, cmd_reg.doc_id, cmd_reg.doc_score);
                    if (can_emit) begin
                        state_next = ST_LOAD;
                    end
                end else begin
                    if (is_right) begin
                        r_we       = 1'b1;
                        r_cnt_next = r_cnt_reg + 1'b1;
                    end else begin
                        l_we       = 1'b1;
                        l_cnt_next = l_cnt_reg + 1'b1;
                    end
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD: begin
                // queue head reads settle
                state_next = ST_DRAIN;
            end

            ST_DRAIN: begin
                if (l_cnt_reg != '0 && r_cnt_reg != '0) begin
                    // both heads present: decide the smaller id
                    if (l_rd_reg.id == r_rd_reg.id) begin
                        state_next = ST_MULT;
                    end else if (l_rd_reg.id < r_rd_reg.id) begin
                        emit_req  = mode_or;
                        emit_item = make_item(KIND_ENTRY, l_rd_reg.id, l_rd_reg.score);
                        if (!mode_or || can_emit) begin
                            l_head_next = ptr_inc(l_head_reg);
                            l_cnt_next  = l_cnt_reg - 1'b1;
                            state_next  = ST_LOAD;
                        end
                    end else begin
                        emit_req  = mode_or;
                        emit_item = make_item(KIND_ENTRY, r_rd_reg.id, r_rd_reg.score);
                        if (!mode_or || can_emit) begin
                            r_head_next = ptr_inc(r_head_reg);
                            r_cnt_next  = r_cnt_reg - 1'b1;
                            state_next  = ST_LOAD;
                        end
                    end
                end else if (mode_or && l_done_reg && l_cnt_reg == '0 && r_cnt_reg != '0) begin
                    // left list over: flush the right queue
                    emit_req  = 1'b1;
                    emit_item = make_item(KIND_ENTRY, r_rd_reg.id, r_rd_reg.score);
                    if (can_emit) begin
                        r_head_next = ptr_inc(r_head_reg);
                        r_cnt_next  = r_cnt_reg - 1'b1;
                        state_next  = ST_LOAD;
                    end
                end else if (mode_or && r_done_reg && r_cnt_reg == '0 && l_cnt_reg != '0) begin
                    // right list over: flush the left queue
                    emit_req  = 1'b1;
                    emit_item = make_item(KIND_ENTRY, l_rd_reg.id, l_rd_reg.score);
                    if (can_emit) begin
                        l_head_next = ptr_inc(l_head_reg);
                        l_cnt_next  = l_cnt_reg - 1'b1;
                        state_next  = ST_LOAD;
                    end
                end else if (( mode_or && l_done_reg && r_done_reg &&
                               l_cnt_reg == '0 && r_cnt_reg == '0) ||
                             (!mode_or && ((l_done_reg && l_cnt_reg == '0) ||
                                           (r_done_reg && r_cnt_reg == '0)))) begin
                    // run end: end result, queued leftovers dropped
                    emit_req  = 1'b1;
                    emit_item = make_item(KIND_END, '0, '0);
                    if (can_emit) begin
                        run_fin_next = 1'b1;
                        l_cnt_next   = '0;
                        r_cnt_next   = '0;
                        if (l_done_reg && r_done_reg) begin
                            run_fin_next = 1'b0;
                            l_done_next  = 1'b0;
                            r_done_next  = 1'b0;
                            l_head_next  = '0;
                            r_head_next  = '0;
                        end
                        state_next = ST_FLUSH;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end

            ST_MULT: begin
                state_next = ST_MATCH;
            end

            ST_MATCH: begin
                // matching ids leave as one weighted entry
                emit_req  = 1'b1;
                emit_item = make_item(KIND_ENTRY, l_rd_reg.id, score_sat);
                if (can_emit) begin
                    l_head_next = ptr_inc(l_head_reg);
                    r_head_next = ptr_inc(r_head_reg);
                    l_cnt_next  = l_cnt_reg - 1'b1;
                    r_cnt_next  = r_cnt_reg - 1'b1;
                    state_next  = ST_LOAD;
                end
            end

            ST_FLUSH: begin
                // the held result is the last one of this transaction
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a new result pushes the held one to the output register
        if (emit_req && can_emit) begin
            if (pend_valid_reg) begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = emit_item;
            pend_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            l_head_reg     <= '0;
            r_head_reg     <= '0;
            l_cnt_reg      <= '0;
            r_cnt_reg      <= '0;
            l_done_reg     <= 1'b0;
            r_done_reg     <= 1'b0;
            run_fin_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            l_head_reg     <= l_head_next;
            r_head_reg     <= r_head_next;
            l_cnt_reg      <= l_cnt_next;
            r_cnt_reg      <= r_cnt_next;
            l_done_reg     <= l_done_next;
            r_done_reg     <= r_done_next;
            run_fin_reg    <= run_fin_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (cmd_valid && cmd_ready) begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_MULT) begin
            prod_l_reg <= l_rd_reg.score * cfg.left_weight;
            prod_r_reg <= r_rd_reg.score * cfg.right_weight;
        end
    end

    // posting queues: one write and one registered head read per side
    always_ff @(posedge aclk) begin
        if (l_we) begin
            l_mem[l_tail] <= wr_entry;
        end
        if (r_we) begin
            r_mem[r_tail] <= wr_entry;
        end
        l_rd_reg <= l_mem[l_head_reg];
        r_rd_reg <= r_mem[r_head_reg];
    end

    // between transactions at most one queue holds postings
    `PLM_ASSERT(a_one_side_idle, (state_reg == ST_IDLE) |-> (l_cnt_reg == '0 || r_cnt_reg == '0))
    // a finished run leaves both queues empty
    `PLM_ASSERT(a_fin_empty, run_fin_reg |-> (l_cnt_reg == '0 && r_cnt_reg == '0))
    // no held result survives the end of a transaction
    `PLM_ASSERT_NEVER(a_no_pend_idle, (state_reg == ST_IDLE) && pend_valid_reg)

endmodule

// ===== rtl/posting_list_merge.sv =====
// posting list merge: merges two ascending posting lists into one scored list.
//
// input channel (s_valid/s_ready/s_data): tagged postings of the left and right
// lists and an end mark per list. result channel (m_valid/m_ready/m_data):
// merged entries, an end result once the run is over, or an overflow report for
// a posting that found its side's queue full; last marks the final result
// caused by one input transaction. config port (cfg_we/cfg_index/cfg_data)
// writes merge_mode, left_weight and right_weight; the user must write them
// only while the block is idle, which the block itself does not enforce.
// a two entry command queue decouples acceptance from the merge sequencer,
// which takes one transaction at a time and the next only once back in idle.
// each head compare passes through the load state and then the drain state,
// because the queue head is read through a registered port. a transaction's
// results wait in the pending register and move on to the output register
// when the next result comes or, for the last one, in the flush state.
// a stalled receiver holds the output register and then stops the sequencer,
// and the command queue fills and drops s_ready. reset (aresetn low, sync)
// empties all queues and clears the run state; no clearing pass is needed.
// weights return to 16 (1.0) and the mode to intersection.
// depends on plm_pkg, plm_front and plm_back
module posting_list_merge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  plm_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output plm_pkg::out_item_t                  m_data,
    input  logic                                cfg_we,
    input  logic [plm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [plm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import plm_pkg::*;

    cfg_t cfg_reg;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.merge_mode   <= 1'b0;
            cfg_reg.left_weight  <= WEIGHT_RESET;
            cfg_reg.right_weight <= WEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MERGE_MODE:   cfg_reg.merge_mode   <= cfg_data[0];
                REG_LEFT_WEIGHT:  cfg_reg.left_weight  <= cfg_data[WEIGHT_W-1:0];
                REG_RIGHT_WEIGHT: cfg_reg.right_weight <= cfg_data[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // accept and classify
    plm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // merge and emit
    plm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== tb/plm_tb_pkg.sv =====
`timescale 1ns / 1ps
// tracker of merged posting list results for the posting list merge testbench
// depends on plm_pkg for the item, result and queue entry types
package plm_tb_pkg;

    import plm_pkg::*;

    localparam bit MODE_INTERSECT = 1'b0;
    localparam bit MODE_UNION     = 1'b1;
    localparam bit SIDE_LEFT      = 1'b0;
    localparam bit SIDE_RIGHT     = 1'b1;

    class merged_list_tracker;

        // postings waiting per side, plus run state
        qentry_t left_list[$];
        qentry_t right_list[$];
        bit left_ended;
        bit right_ended;
        bit run_over;

        // register copies
        bit                  union_mode = MODE_INTERSECT;
        logic [WEIGHT_W-1:0] left_w     = WEIGHT_RESET;
        logic [WEIGHT_W-1:0] right_w    = WEIGHT_RESET;

        out_item_t step_results[$];
        out_item_t pending_results[$];
        int errors;

        function void set_config(bit mode, logic [WEIGHT_W-1:0] lw, logic [WEIGHT_W-1:0] rw);
            union_mode = mode;
            left_w     = lw;
            right_w    = rw;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void clear_run();
            left_list.delete();
            right_list.delete();
            left_ended  = 1'b0;
            right_ended = 1'b0;
            run_over    = 1'b0;
        endfunction

        // q8.8 times q4.4, summed exactly, back to q8.8 and saturated
        function logic [SCORE_W-1:0] weighted_score(logic [SCORE_W-1:0] ls,
                                                     logic [SCORE_W-1:0] rs);
            logic [31:0] total;
            total = (32'(ls) * 32'(left_w) + 32'(rs) * 32'(right_w)) >> FRAC_SHIFT;
            return (total > 32'hFFFF) ? 16'hFFFF : total[SCORE_W-1:0];
        endfunction

        function void add_result(kind_t k, logic [ID_W-1:0] doc, logic [SCORE_W-1:0] sc);
            out_item_t r;
            r.kind       = k;
            r.out_doc    = doc;
            r.out_score  = sc;
            r.last       = 1'b0;
            step_results = {step_results, r};
        endfunction

        function void end_run();
            add_result(KIND_END, '0, '0);
            run_over = 1'b1;
            left_list.delete();
            right_list.delete();
            if (left_ended && right_ended) begin
                clear_run();
            end
        endfunction

        // decide heads while both sides hold postings, then flush or close the run
        function void drain_heads();
            qentry_t a;
            qentry_t b;
            while (left_list.size() != 0 && right_list.size() != 0) begin
                a = left_list[0];
                b = right_list[0];
                if (a.id == b.id) begin
                    add_result(KIND_ENTRY, a.id, weighted_score(a.score, b.score));
                    void'(left_list.pop_front());
                    void'(right_list.pop_front());
                end else if (a.id < b.id) begin
                    if (union_mode) begin
                        add_result(KIND_ENTRY, a.id, a.score);
                    end
                    void'(left_list.pop_front());
                end else begin
                    if (union_mode) begin
                        add_result(KIND_ENTRY, b.id, b.score);
                    end
                    void'(right_list.pop_front());
                end
            end
            if (!union_mode) begin
                if ((left_ended && left_list.size() == 0) ||
                    (right_ended && right_list.size() == 0)) begin
                    end_run();
                end
                return;
            end
            if (left_ended && left_list.size() == 0) begin
                while (right_list.size() != 0) begin
                    add_result(KIND_ENTRY, right_list[0].id, right_list[0].score);
                    void'(right_list.pop_front());
                end
            end
            if (right_ended && right_list.size() == 0) begin
                while (left_list.size() != 0) begin
                    add_result(KIND_ENTRY, left_list[0].id, left_list[0].score);
                    void'(left_list.pop_front());
                end
            end
            if (left_ended && right_ended && left_list.size() == 0 && right_list.size() == 0) begin
                end_run();
            end
        endfunction

        // work out the results caused by one accepted input transaction
        function void predict_merge(in_item_t item);
            qentry_t e;
            step_results.delete();
            e.id    = item.doc_id;
            e.score = item.doc_score;
            // after run end only end marks matter
            if (run_over) begin
                if (item.list_end) begin
                    if (item.side == SIDE_RIGHT) right_ended = 1'b1;
                    else left_ended = 1'b1;
                    if (left_ended && right_ended) begin
                        clear_run();
                    end
                end
                return;
            end
            if (item.list_end) begin
                if (item.side == SIDE_RIGHT) right_ended = 1'b1;
                else left_ended = 1'b1;
            end else if (item.side == SIDE_RIGHT) begin
                if (!right_ended) begin
                    if (right_list.size() >= QUEUE_DEPTH) begin
                        add_result(KIND_OVERFLOW, item.doc_id, item.doc_score);
                    end else begin
                        right_list = {right_list, e};
                    end
                end
            end else begin
                if (!left_ended) begin
                    if (left_list.size() >= QUEUE_DEPTH) begin
                        add_result(KIND_OVERFLOW, item.doc_id, item.doc_score);
                    end else begin
                        left_list = {left_list, e};
                    end
                end
            end
            drain_heads();
            if (step_results.size() != 0) begin
                step_results[step_results.size() - 1].last = 1'b1;
            end
            foreach (step_results[i]) begin
                pending_results = {pending_results, step_results[i]};
            end
        endfunction

        // compare one result transaction with the oldest expected one
        function void compare_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d doc %h score %h last %0d",
                       got.kind, got.out_doc, got.out_score, got.last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind mismatch: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.out_doc !== want.out_doc) begin
                $error("out_doc mismatch: expected %h, got %h", want.out_doc, got.out_doc);
                errors++;
            end
            if (got.out_score !== want.out_score) begin
                $error("out_score mismatch: expected %h, got %h", want.out_score, got.out_score);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last mismatch: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top of the posting list merge testbench: clock, reset, stimulus and result checking
// depends on plm_pkg, plm_tb_pkg and the posting_list_merge rtl
module testbench;

    import plm_pkg::*;
    import plm_tb_pkg::*;

    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 22;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int s_idle_pct  = 0;
    int m_stall_pct = 0;
    int items_sent  = 0;
    bit hold_request = 1'b0;
    bit hold_taken   = 1'b0;
    int hold_left    = 0;

    merged_list_tracker merged_list = new();

    posting_list_merge dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: check each accepted transaction, then pick the next ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                merged_list.compare_result(m_data);
            end
            if (hold_request && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                m_ready    <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= m_stall_pct);
            end
        end
    end

    function automatic logic [SCORE_W-1:0] random_score();
        unique case ($urandom_range(7))
            0: return 16'hFFFF;
            1: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    // offer one transaction and wait for it to be taken
    task automatic send_item(input in_item_t item);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        merged_list.predict_merge(item);
        items_sent++;
    endtask

    task automatic send_doc(input bit side, input logic [ID_W-1:0] id,
                            input logic [SCORE_W-1:0] sc);
        in_item_t item;
        item.side      = side;
        item.list_end  = 1'b0;
        item.doc_id    = id;
        item.doc_score = sc;
        send_item(item);
    endtask

    // end mark; doc fields carry junk that the block must ignore
    task automatic send_mark(input bit side);
        in_item_t item;
        item.side      = side;
        item.list_end  = 1'b1;
        item.doc_id    = $urandom();
        item.doc_score = 16'($urandom());
        send_item(item);
    endtask

    // stop offering, let every expected result arrive, then let the block settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (merged_list.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic apply_config(input bit mode, input logic [WEIGHT_W-1:0] lw,
                                input logic [WEIGHT_W-1:0] rw);
        write_reg(REG_MERGE_MODE, CFG_DATA_W'(mode));
        write_reg(REG_LEFT_WEIGHT, lw);
        write_reg(REG_RIGHT_WEIGHT, rw);
        cfg_we <= 1'b0;
        merged_list.set_config(mode, lw, rw);
    endtask

    // random transactions: any side, stray end marks, unordered ids
    task automatic noise_burst();
        in_item_t item;
        repeat ($urandom_range(1, 6)) begin
            item.side      = 1'($urandom_range(1));
            item.list_end  = ($urandom_range(5) == 0);
            item.doc_id    = $urandom();
            item.doc_score = random_score();
            send_item(item);
        end
    endtask

    // two ascending lists over shared ids, each closed by its end mark;
    // a burst sends one long list first so that its queue overflows
    task automatic random_run();
        qentry_t seq_l[$];
        qentry_t seq_r[$];
        qentry_t e;
        bit burst;
        bit heavy;
        bit to_l;
        bit to_r;
        bit side;
        bit done_l;
        bit done_r;
        int len;
        int pick;
        int kl;
        int kr;
        logic [ID_W-1:0] id;
        burst  = ($urandom_range(7) == 0);
        heavy  = 1'($urandom_range(1));
        len    = burst ? $urandom_range(18, 24) : $urandom_range(0, 8);
        id     = ($urandom_range(9) == 0) ? '0 : $urandom();
        done_l = 1'b0;
        done_r = 1'b0;
        kl     = 0;
        kr     = 0;
        for (int k = 0; k < len; k++) begin
            id   = id + $urandom_range(1, 3);
            pick = burst ? $urandom_range(4) : $urandom_range(2);
            if (burst) begin
                to_l = (heavy == SIDE_LEFT) || (pick == 4);
                to_r = (heavy == SIDE_RIGHT) || (pick == 4);
            end else begin
                to_l = (pick != 1);
                to_r = (pick != 0);
            end
            if (to_l) begin
                e.id    = id;
                e.score = random_score();
                seq_l   = {seq_l, e};
            end
            if (to_r) begin
                e.id    = id;
                e.score = random_score();
                seq_r   = {seq_r, e};
            end
        end
        while (!done_l || !done_r) begin
            if (done_l) side = SIDE_RIGHT;
            else if (done_r) side = SIDE_LEFT;
            else if (burst) side = heavy;
            else side = 1'($urandom_range(1));
            if (side == SIDE_LEFT) begin
                if (kl < seq_l.size()) begin
                    send_doc(SIDE_LEFT, seq_l[kl].id, seq_l[kl].score);
                    kl++;
                end else begin
                    send_mark(SIDE_LEFT);
                    done_l = 1'b1;
                end
            end else begin
                if (kr < seq_r.size()) begin
                    send_doc(SIDE_RIGHT, seq_r[kr].id, seq_r[kr].score);
                    kr++;
                end else begin
                    send_mark(SIDE_RIGHT);
                    done_r = 1'b1;
                end
            end
        end
    endtask

    // main sequence
    initial begin
        int goal;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // intersection at reset weights: saturated match, discard, run end,
        // items dropped after run end, repeated end mark
        send_doc(SIDE_LEFT, 32'd5, 16'hFFFF);
        send_doc(SIDE_RIGHT, 32'd5, 16'hFFFF);
        send_doc(SIDE_LEFT, 32'd7, 16'h0100);
        send_doc(SIDE_RIGHT, 32'd6, 16'h00FF);
        send_doc(SIDE_RIGHT, 32'd7, 16'h0001);
        send_doc(SIDE_LEFT, 32'hFFFF_FFFF, 16'h0000);
        send_mark(SIDE_RIGHT);
        send_doc(SIDE_LEFT, 32'h1234_5678, 16'h5678);
        send_mark(SIDE_RIGHT);
        send_mark(SIDE_LEFT);
        wait_drained();

        // union with lopsided weights: unordered ids, data after end mark,
        // saturation, lone-side flush
        apply_config(MODE_UNION, 8'd255, 8'd0);
        send_doc(SIDE_LEFT, 32'd3, 16'h8000);
        send_doc(SIDE_LEFT, 32'd0, 16'h1234);
        send_doc(SIDE_RIGHT, 32'd2, 16'hABCD);
        send_mark(SIDE_LEFT);
        send_doc(SIDE_LEFT, 32'd10, 16'h5555);
        send_mark(SIDE_LEFT);
        send_doc(SIDE_RIGHT, 32'd3, 16'hFFFF);
        send_doc(SIDE_RIGHT, 32'hFFFF_FFFF, 16'h0001);
        send_mark(SIDE_RIGHT);

        // random phases over register settings and idling patterns
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            unique case (p)
                0: apply_config(MODE_INTERSECT, 8'd16, 8'd16);
                1: apply_config(MODE_UNION, 8'd255, 8'd255);
                2: apply_config(MODE_INTERSECT, 8'd0, 8'd255);
                3: apply_config(MODE_UNION, 8'd255, 8'd0);
                4: apply_config(MODE_UNION, 8'($urandom()), 8'($urandom()));
                5: apply_config(MODE_INTERSECT, 8'($urandom()), 8'($urandom()));
                6: apply_config(MODE_UNION, 8'd0, 8'd0);
                default: apply_config(MODE_INTERSECT, 8'($urandom()), 8'($urandom()));
            endcase
            unique case (p % 4)
                0: begin
                    s_idle_pct  = 0;
                    m_stall_pct = 0;
                end
                1: begin
                    s_idle_pct  = 60;
                    m_stall_pct = 0;
                end
                2: begin
                    s_idle_pct  = 0;
                    m_stall_pct = 60;
                end
                default: begin
                    s_idle_pct  = 16;
                    m_stall_pct = 16;
                end
            endcase
            // long receiver hold while the sender keeps offering
            if (p == 4) begin
                hold_request <= 1'b1;
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                if ($urandom_range(4) == 0) noise_burst();
                else random_run();
            end
            // both end marks always return the run state to reset
            send_mark(SIDE_LEFT);
            send_mark(SIDE_RIGHT);
        end

        wait_drained();
        if (merged_list.errors == 0 && merged_list.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/plm_pkg.sv
rtl/plm_front.sv
rtl/plm_back.sv
rtl/posting_list_merge.sv
tb/plm_tb_pkg.sv
tb/testbench.sv
